/* rtl/spt_pkg.sv */
// shared constants and codes for the swing pivot tracker
package spt_pkg;

   // default field widths
   localparam int PRICE_BITS_DEFAULT = 32;
   localparam int TIME_BITS_DEFAULT  = 48;

   // threshold register, unsigned q0.16
   localparam int                      THRESHOLD_BITS  = 16;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd655;

   // register file port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   // word index of the threshold register
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   // result kinds
   localparam logic KIND_NEW  = 1'b0;
   localparam logic KIND_MOVE = 1'b1;

   // result queue between the tracker and the rsp channel
   localparam int OUTQ_DEPTH    = 4;
   localparam int OUTQ_PTR_BITS = 2;
   localparam int OUTQ_CNT_BITS = 3;
   localparam int PUSH_BITS     = 2;
   localparam int MAX_PUSH      = 2;

endpackage

/* rtl/spt_channels.sv */
// valid/ready channel interfaces for samples and pivot results
interface spt_req_if #(
   parameter int TIME_BITS  = spt_pkg::TIME_BITS_DEFAULT,
   parameter int PRICE_BITS = spt_pkg::PRICE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [TIME_BITS-1:0]  sample_time;
   logic [PRICE_BITS-1:0] sample_price;

   modport source (output valid, sample_time, sample_price, input ready);
   modport sink   (input valid, sample_time, sample_price, output ready);
endinterface

interface spt_rsp_if #(
   parameter int TIME_BITS  = spt_pkg::TIME_BITS_DEFAULT,
   parameter int PRICE_BITS = spt_pkg::PRICE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  event_kind;
   logic [TIME_BITS-1:0]  pivot_time;
   logic [PRICE_BITS-1:0] pivot_price;
   logic                  pivot_is_high;
   logic                  last_of_run;

   modport source (output valid, event_kind, pivot_time, pivot_price, pivot_is_high,
                   last_of_run, input ready);
   modport sink   (input valid, event_kind, pivot_time, pivot_price, pivot_is_high,
                   last_of_run, output ready);
endinterface

/* rtl/spt_core.sv */
// sample register, zigzag pivot state and result generation
module spt_core #(
   parameter int TIME_BITS  = spt_pkg::TIME_BITS_DEFAULT,
   parameter int PRICE_BITS = spt_pkg::PRICE_BITS_DEFAULT,
   parameter int ENTRY_BITS = TIME_BITS + PRICE_BITS + 3
) (
   input  logic                              clock,
   input  logic                              reset,
   spt_req_if.sink                           req,
   input  logic [spt_pkg::THRESHOLD_BITS-1:0] threshold_frac,
   input  logic                              room,
   output logic [spt_pkg::PUSH_BITS-1:0]     push_n,
   output logic [ENTRY_BITS-1:0]             entry0,
   output logic [ENTRY_BITS-1:0]             entry1
);

   localparam int PROD_BITS = PRICE_BITS + spt_pkg::THRESHOLD_BITS;

   // sample stage
   logic                  s_valid_ff, s_valid_in;
   logic [TIME_BITS-1:0]  s_time_ff, s_time_in;
   logic [PRICE_BITS-1:0] s_price_ff, s_price_in;

   // tracker state
   logic                  ev_ff, ev_in;
   logic                  started_ff, started_in;
   logic [TIME_BITS-1:0]  low_time_ff, low_time_in;
   logic [PRICE_BITS-1:0] low_price_ff, low_price_in;
   logic [TIME_BITS-1:0]  high_time_ff, high_time_in;
   logic [PRICE_BITS-1:0] high_price_ff, high_price_in;
   logic [TIME_BITS-1:0]  last_time_ff, last_time_in;
   logic [PRICE_BITS-1:0] last_price_ff, last_price_in;
   logic                  last_is_high_ff, last_is_high_in;

   logic                  accept;
   logic                  fire;
   logic [TIME_BITS-1:0]  lt0, ht0, lt_n, ht_n;
   logic [PRICE_BITS-1:0] lp0, hp0, lp_n, hp_n;
   logic                  low_first;
   logic [PRICE_BITS-1:0] base;
   logic [PROD_BITS-1:0]  prod;
   logic [PRICE_BITS-1:0] q;
   logic [PRICE_BITS-1:0] cmp_hi, cmp_lo;
   logic [PRICE_BITS-1:0] diff;
   logic                  beyond;
   logic                  move;
   logic                  rev;
   logic                  first;
   logic [TIME_BITS-1:0]  early_time, later_time;
   logic [PRICE_BITS-1:0] early_price, later_price;

   // input handshake: the stage frees up when its sample is processed
   assign fire      = s_valid_ff & room;
   assign req.ready = ~s_valid_ff | fire;
   assign accept    = req.valid & req.ready;

   always_comb begin
      s_valid_in = s_valid_ff;
      s_time_in  = s_time_ff;
      s_price_in = s_price_ff;
      if (accept) begin
         s_valid_in = 1'b1;
         s_time_in  = req.sample_time;
         s_price_in = req.sample_price;
      end else if (fire) begin
         s_valid_in = 1'b0;
      end
   end

   // running extremes, the first sample seeds both
   always_comb begin
      lt0  = ev_ff ? low_time_ff   : s_time_ff;
      lp0  = ev_ff ? low_price_ff  : s_price_ff;
      ht0  = ev_ff ? high_time_ff  : s_time_ff;
      hp0  = ev_ff ? high_price_ff : s_price_ff;
      hp_n = (s_price_ff > hp0) ? s_price_ff : hp0;
      ht_n = (s_price_ff > hp0) ? s_time_ff  : ht0;
      lp_n = (s_price_ff < lp0) ? s_price_ff : lp0;
      lt_n = (s_price_ff < lp0) ? s_time_ff  : lt0;
      // equal times count as high first
      low_first = lt_n < ht_n;
   end

   // threshold test: (hi - lo) > floor(base * d / 2^16)
   always_comb begin
      if (started_ff) begin
         base = last_price_ff;
      end else begin
         base = low_first ? lp_n : hp_n;
      end
      prod = PROD_BITS'(base) * PROD_BITS'(threshold_frac);
      q    = prod[PROD_BITS-1:spt_pkg::THRESHOLD_BITS];
      if (!started_ff) begin
         cmp_hi = hp_n;
         cmp_lo = lp_n;
      end else if (last_is_high_ff) begin
         cmp_hi = last_price_ff;
         cmp_lo = s_price_ff;
      end else begin
         cmp_hi = s_price_ff;
         cmp_lo = last_price_ff;
      end
      diff   = cmp_hi - cmp_lo;
      beyond = (cmp_hi > cmp_lo) && (diff > q);
   end

   // decisions for this sample
   assign move  = started_ff && (last_is_high_ff ? (s_price_ff > last_price_ff)
                                                 : (s_price_ff < last_price_ff));
   assign rev   = started_ff & ~move & beyond;
   assign first = ~started_ff & beyond;

   // earlier and later extreme of the first swing
   assign early_time  = low_first ? lt_n : ht_n;
   assign early_price = low_first ? lp_n : hp_n;
   assign later_time  = low_first ? ht_n : lt_n;
   assign later_price = low_first ? hp_n : lp_n;

   // result words: kind, time, price, high mark, last of run
   always_comb begin
      if (!fire) begin
         push_n = spt_pkg::PUSH_BITS'(0);
      end else if (first) begin
         push_n = spt_pkg::PUSH_BITS'(2);
      end else if (move || rev) begin
         push_n = spt_pkg::PUSH_BITS'(1);
      end else begin
         push_n = spt_pkg::PUSH_BITS'(0);
      end
      if (first) begin
         entry0 = {spt_pkg::KIND_NEW, early_time, early_price, ~low_first, 1'b0};
      end else begin
         entry0 = {(move ? spt_pkg::KIND_MOVE : spt_pkg::KIND_NEW), s_time_ff, s_price_ff,
                   (move ? last_is_high_ff : ~last_is_high_ff), 1'b1};
      end
      entry1 = {spt_pkg::KIND_NEW, later_time, later_price, low_first, 1'b1};
   end

   // next state
   always_comb begin
      ev_in           = ev_ff;
      started_in      = started_ff;
      low_time_in     = low_time_ff;
      low_price_in    = low_price_ff;
      high_time_in    = high_time_ff;
      high_price_in   = high_price_ff;
      last_time_in    = last_time_ff;
      last_price_in   = last_price_ff;
      last_is_high_in = last_is_high_ff;
      if (fire) begin
         if (!started_ff) begin
            ev_in         = 1'b1;
            low_time_in   = lt_n;
            low_price_in  = lp_n;
            high_time_in  = ht_n;
            high_price_in = hp_n;
            if (first) begin
               started_in      = 1'b1;
               last_time_in    = later_time;
               last_price_in   = later_price;
               last_is_high_in = low_first;
            end
         end else if (move || rev) begin
            last_time_in  = s_time_ff;
            last_price_in = s_price_ff;
            if (rev) begin
               last_is_high_in = ~last_is_high_ff;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff      <= 1'b0;
         ev_ff           <= 1'b0;
         started_ff      <= 1'b0;
         last_is_high_ff <= 1'b0;
      end else begin
         s_valid_ff      <= s_valid_in;
         ev_ff           <= ev_in;
         started_ff      <= started_in;
         last_is_high_ff <= last_is_high_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      s_time_ff     <= s_time_in;
      s_price_ff    <= s_price_in;
      low_time_ff   <= low_time_in;
      low_price_ff  <= low_price_in;
      high_time_ff  <= high_time_in;
      high_price_ff <= high_price_in;
      last_time_ff  <= last_time_in;
      last_price_ff <= last_price_in;
   end

`ifndef SYNTHESIS
   // a confirmed swing always rests on seeded extremes
   a_started_seeded: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> ev_ff)
      else $error("started without seeded extremes");

   // a pair of results only comes from the first swing
   a_pair_first_only: assert property (@(posedge clock) disable iff (reset)
      (push_n == spt_pkg::PUSH_BITS'(2)) |=> started_ff && !$past(started_ff))
      else $error("pair of results outside the first swing");

   // a waiting sample stays put until it is processed
   a_sample_held: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && !fire) |=> (s_valid_ff && $stable(s_time_ff) && $stable(s_price_ff)))
      else $error("waiting sample lost or changed");
`endif

endmodule

/* rtl/spt_outq.sv */
// four-word result queue feeding the rsp channel
module spt_outq #(
   parameter int TIME_BITS  = spt_pkg::TIME_BITS_DEFAULT,
   parameter int PRICE_BITS = spt_pkg::PRICE_BITS_DEFAULT,
   parameter int ENTRY_BITS = TIME_BITS + PRICE_BITS + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [spt_pkg::PUSH_BITS-1:0] push_n,
   input  logic [ENTRY_BITS-1:0]         entry0,
   input  logic [ENTRY_BITS-1:0]         entry1,
   output logic                          room,
   spt_rsp_if.source                     rsp
);

   logic [ENTRY_BITS-1:0]             entry_ff [spt_pkg::OUTQ_DEPTH];
   logic [spt_pkg::OUTQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [spt_pkg::OUTQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [spt_pkg::OUTQ_CNT_BITS-1:0] count_ff, count_in;
   logic [spt_pkg::OUTQ_PTR_BITS-1:0] wr_next;
   logic                              pop;
   logic [ENTRY_BITS-1:0]             head;

   // space for a full pair of words
   assign room = count_ff <= spt_pkg::OUTQ_CNT_BITS'(spt_pkg::OUTQ_DEPTH - spt_pkg::MAX_PUSH);

   // head word onto the channel
   assign head              = entry_ff[rd_ptr_ff];
   assign rsp.valid         = count_ff != '0;
   assign rsp.event_kind    = head[ENTRY_BITS-1];
   assign rsp.pivot_time    = head[ENTRY_BITS-2 -: TIME_BITS];
   assign rsp.pivot_price   = head[PRICE_BITS+1 -: PRICE_BITS];
   assign rsp.pivot_is_high = head[1];
   assign rsp.last_of_run   = head[0];
   assign pop               = rsp.valid & rsp.ready;

   // pointers and fill count
   assign wr_next   = wr_ptr_ff + spt_pkg::OUTQ_PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + spt_pkg::OUTQ_PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + spt_pkg::OUTQ_PTR_BITS'(pop);
   assign count_in  = count_ff + spt_pkg::OUTQ_CNT_BITS'(push_n)
                      - spt_pkg::OUTQ_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         entry_ff[wr_ptr_ff] <= entry0;
      end
      if (push_n == spt_pkg::PUSH_BITS'(2)) begin
         entry_ff[wr_next] <= entry1;
      end
   end

`ifndef SYNTHESIS
   // never fuller than the storage
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spt_pkg::OUTQ_CNT_BITS'(spt_pkg::OUTQ_DEPTH))
      else $error("result queue overfilled");

   // words only arrive while a pair still fits
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_n != '0) |-> room)
      else $error("push without room");

   // fill count follows pointers
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != spt_pkg::OUTQ_CNT_BITS'(spt_pkg::OUTQ_DEPTH)) |->
         (spt_pkg::OUTQ_PTR_BITS'(wr_ptr_ff - rd_ptr_ff) ==
          spt_pkg::OUTQ_PTR_BITS'(count_ff)))
      else $error("fill count and pointers disagree");
`endif

endmodule

/* rtl/swing_pivot_tracker.sv */
// zigzag swing pivot tracker: top level with threshold register
//
//  channel  dir  handshake           word
//  req      in   valid/ready         sample_time, sample_price
//  rsp      out  valid/ready         event_kind, pivot_time, pivot_price,
//                                    pivot_is_high, last_of_run
//  csr      in   psel/penable/pwrite threshold_frac at word 0, pready tied high
//
// one sample a cycle while the queue has room; a taken sample is held in the sample register,
// then its result words are written to the queue, whose head word drives rsp
// a sample confirming the first swing gives two words, which the rsp side
// drains at one word a cycle while rsp ready is high, from a four-word queue
// a sample waits in the sample register while the queue lacks room for two words
// reset clears the tracker and queue control and loads the threshold with 655
module swing_pivot_tracker #(
   parameter int TIME_BITS  = spt_pkg::TIME_BITS_DEFAULT,
   parameter int PRICE_BITS = spt_pkg::PRICE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   spt_req_if.sink                           req_chan,
   spt_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [spt_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [spt_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int ENTRY_BITS = TIME_BITS + PRICE_BITS + 3;

   logic [spt_pkg::THRESHOLD_BITS-1:0] threshold_ff, threshold_in;
   logic                               csr_hit;
   logic                               room;
   logic [spt_pkg::PUSH_BITS-1:0]      push_n;
   logic [ENTRY_BITS-1:0]              entry0;
   logic [ENTRY_BITS-1:0]              entry1;

   // register port, word index from the upper address bit
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[spt_pkg::CSR_ADDR_BITS-1] == spt_pkg::CSR_IDX_THRESHOLD;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         threshold_in = csr_pwdata[spt_pkg::THRESHOLD_BITS-1:0];
      end
   end

   always_comb begin
      if (csr_hit) begin
         csr_prdata = spt_pkg::CSR_DATA_BITS'(threshold_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= spt_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // pivot tracking
   spt_core #(
      .TIME_BITS  (TIME_BITS),
      .PRICE_BITS (PRICE_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .threshold_frac (threshold_ff),
      .room           (room),
      .push_n         (push_n),
      .entry0         (entry0),
      .entry1         (entry1)
   );

   // result queue
   spt_outq #(
      .TIME_BITS  (TIME_BITS),
      .PRICE_BITS (PRICE_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_outq (
      .clock  (clock),
      .reset  (reset),
      .push_n (push_n),
      .entry0 (entry0),
      .entry1 (entry1),
      .room   (room),
      .rsp    (rsp_chan)
   );

endmodule
